@@ rtl/vha_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package vha_pkg;
  localparam int COORD_W = 21;
  localparam int VALUE_W = 32;
  localparam logic [31:0] HASH_MUL_X = 32'd73856093;
  localparam logic [31:0] HASH_MUL_Y = 32'd19349663;
  localparam logic [31:0] HASH_MUL_Z = 32'd83492791;

  // configuration register index on paddr
  localparam logic [1:0] REG_SLOTS = 2'd0;

  typedef enum logic [1:0] {
    ST_NEW   = 2'd0,
    ST_ACC   = 2'd1,
    ST_DROP  = 2'd2,
    ST_CLEAR = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    KIND_INSERT = 1'b0,
    KIND_CLEAR  = 1'b1
  } kind_t;

  // classified item handed from the front part to the back part
  typedef struct packed {
    logic        clear;
    logic [31:0] key_x;
    logic [31:0] key_y;
    logic [31:0] key_z;
    logic [31:0] value;
    logic [31:0] hash;
  } work_t;

  typedef enum logic [3:0] {
    BK_INIT,
    BK_IDLE,
    BK_MOD,
    BK_READ,
    BK_WAIT,
    BK_CHECK,
    BK_WRITE,
    BK_CLEAR,
    BK_OUT
  } back_state_t;
endpackage
`default_nettype wire

@@ rtl/voxel_hash_accumulate_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Voxel hash accumulator. After reset the slot valid bits are cleared in a
// pass over all MAX_SLOTS slots; items are held in the front until it ends.
// An insert goes through these steps from accept to result: two front stages
// hash the coordinates, the back end picks the item up in BK_IDLE, a
// bit-serial remainder reduces the hash by the slot limit register (clamped
// to 1..MAX_SLOTS), each slot of the single-port memory is probed through
// BK_READ, BK_WAIT and BK_CHECK, and a store or update also passes BK_WRITE
// (a drop skips it). A clear walks all MAX_SLOTS slots, one per cycle. One
// item is in the back end at a time; the front holds up to two more.
module voxel_hash_accumulate_unit #(
  parameter int MAX_SLOTS = 4096,
  parameter int COORD_BITS = 21
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         push,
  output logic                        full,
  input  wire                         kind,
  input  wire  signed [COORD_BITS-1:0] coord_x,
  input  wire  signed [COORD_BITS-1:0] coord_y,
  input  wire  signed [COORD_BITS-1:0] coord_z,
  input  wire  signed [31:0]          sample_value,
  output logic                        empty,
  input  wire                         pop,
  output logic [1:0]                  status,
  output logic [$clog2(MAX_SLOTS)-1:0] slot_index,
  output logic signed [31:0]          entry_value,
  output logic [12:0]                 entries_used,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire  [1:0]                  paddr,
  input  wire  [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import vha_pkg::*;

  localparam int AW = $clog2(MAX_SLOTS);

  logic [12:0] slot_limit;
  logic [AW:0] size;
  logic        in_ready, q_valid, q_ready, res_valid;
  work_t       q_data;
  logic [31:0] res_value;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) slot_limit <= 13'd4096;
    else if (psel && penable && pwrite && paddr == REG_SLOTS) slot_limit <= pwdata[12:0];
  end
  assign prdata = (paddr == REG_SLOTS) ? {19'd0, slot_limit} : 32'd0;

  always_comb begin
    if (slot_limit == 13'd0) size = (AW+1)'(1);
    else if (32'(slot_limit) > MAX_SLOTS) size = (AW+1)'(MAX_SLOTS);
    else size = (AW+1)'(slot_limit);
  end

  assign full = !in_ready;

  vha_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk, .rst, .in_valid(push), .in_ready, .kind, .coord_x, .coord_y,
    .coord_z, .sample_value, .q_data, .q_valid, .q_ready
  );

  vha_back #(.MAX_SLOTS(MAX_SLOTS), .COORD_BITS(COORD_BITS)) u_back (
    .clk, .rst, .q_data, .q_valid, .q_ready, .size, .res_valid,
    .res_ready(pop), .res_status(status), .res_slot(slot_index),
    .res_value, .res_used(entries_used)
  );

  assign entry_value = res_value;
  assign empty = !res_valid;
endmodule
`default_nettype wire

@@ rtl/vha_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module vha_front #(
  parameter int COORD_BITS = 21
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire                      kind,
  input  wire  signed [COORD_BITS-1:0] coord_x,
  input  wire  signed [COORD_BITS-1:0] coord_y,
  input  wire  signed [COORD_BITS-1:0] coord_z,
  input  wire  signed [31:0]       sample_value,
  output vha_pkg::work_t           q_data,
  output logic                     q_valid,
  input  wire                      q_ready
);
  import vha_pkg::*;

  // stage 1: extend and multiply, stage 2: xor and hand off
  logic        s1_valid;
  logic        s1_clear;
  logic [31:0] s1_x, s1_y, s1_z, s1_v;
  logic [31:0] s1_px, s1_py, s1_pz;
  logic        s2_valid;
  work_t       s2;
  logic        s2_ready;
  logic [31:0] ex, ey, ez;

  assign ex = 32'(signed'(coord_x));
  assign ey = 32'(signed'(coord_y));
  assign ez = 32'(signed'(coord_z));

  assign s2_ready = !s2_valid || q_ready;
  assign in_ready = !s1_valid || s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (s2_ready) s2_valid <= s1_valid;
    end
    if (in_ready && in_valid) begin
      s1_clear <= (kind == KIND_CLEAR);
      s1_x <= ex;
      s1_y <= ey;
      s1_z <= ez;
      s1_v <= sample_value;
      s1_px <= HASH_MUL_X * ex;
      s1_py <= HASH_MUL_Y * ey;
      s1_pz <= HASH_MUL_Z * ez;
    end
    if (s2_ready && s1_valid) begin
      s2.clear <= s1_clear;
      s2.key_x <= s1_x;
      s2.key_y <= s1_y;
      s2.key_z <= s1_z;
      s2.value <= s1_v;
      s2.hash  <= s1_px ^ s1_py ^ s1_pz;
    end
  end

  assign q_valid = s2_valid;
  assign q_data  = s2;
endmodule
`default_nettype wire

@@ rtl/vha_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module vha_back #(
  parameter int MAX_SLOTS = 4096,
  parameter int COORD_BITS = 21
) (
  input  wire                       clk,
  input  wire                       rst,
  input  vha_pkg::work_t            q_data,
  input  wire                       q_valid,
  output logic                      q_ready,
  input  wire  [$clog2(MAX_SLOTS):0] size,
  output logic                      res_valid,
  input  wire                       res_ready,
  output logic [1:0]                res_status,
  output logic [$clog2(MAX_SLOTS)-1:0] res_slot,
  output logic [31:0]               res_value,
  output logic [12:0]               res_used
);
  import vha_pkg::*;

  localparam int AW = $clog2(MAX_SLOTS);
  localparam int KW = 3 * COORD_BITS;

  logic [KW-1:0] key_mem [MAX_SLOTS];
  logic [31:0]   val_mem [MAX_SLOTS];
  logic          occ_mem [MAX_SLOTS];

  back_state_t state, state_next;
  work_t       item;
  logic [31:0] rem;
  logic [5:0]  mod_bit;
  logic [AW-1:0] idx;
  logic [AW:0]   probes;
  logic [AW:0]   count;
  logic [KW-1:0] rd_key;
  logic [31:0]   rd_val;
  logic          rd_occ;
  logic [KW-1:0] my_key;
  logic [AW:0]   clr_idx;
  logic [32:0]   trial;
  logic [32:0]   sum;
  logic [31:0]   sat;
  logic [AW:0]   idx_inc;

  assign my_key = {item.key_z[COORD_BITS-1:0], item.key_y[COORD_BITS-1:0],
                   item.key_x[COORD_BITS-1:0]};
  // restoring remainder, one quotient bit per cycle
  assign trial = {rem, item.hash[mod_bit[4:0]]} - 33'(size);
  assign sum = {rd_val[31], rd_val} + {item.value[31], item.value};
  always_comb begin
    if (sum[32] != sum[31]) sat = sum[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    else sat = sum[31:0];
  end
  assign idx_inc = {1'b0, idx} + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) state <= BK_INIT;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_ready = 1'b0;
    unique case (state)
      BK_INIT:  if (clr_idx == (AW+1)'(MAX_SLOTS - 1)) state_next = BK_IDLE;
      BK_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) state_next = q_data.clear ? BK_CLEAR : BK_MOD;
      end
      BK_MOD:   if (mod_bit == 6'd0) state_next = BK_READ;
      BK_READ:  state_next = BK_WAIT;
      BK_WAIT:  state_next = BK_CHECK;
      BK_CHECK: begin
        if (!rd_occ || rd_key == my_key) state_next = BK_WRITE;
        else if (probes + 1'b1 >= size) state_next = BK_OUT;
        else state_next = BK_READ;
      end
      BK_WRITE: state_next = BK_OUT;
      BK_CLEAR: if (clr_idx == (AW+1)'(MAX_SLOTS - 1)) state_next = BK_OUT;
      BK_OUT:   if (res_ready) state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  // slot walk shared by the reset pass and the clear item
  always_ff @(posedge clk) begin
    if (rst || state == BK_IDLE) clr_idx <= '0;
    else if (state == BK_CLEAR || state == BK_INIT) clr_idx <= clr_idx + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (state == BK_CLEAR) begin
      count <= '0;
    end else if (state == BK_CHECK && !rd_occ) begin
      count <= count + 1'b1;
    end
    if (state == BK_READ) begin
      rd_key <= key_mem[idx];
      rd_val <= val_mem[idx];
    end
    if (rst) rd_occ <= 1'b0;
    else if (state == BK_READ) rd_occ <= occ_mem[idx];
    if (state == BK_CLEAR || state == BK_INIT) occ_mem[clr_idx[AW-1:0]] <= 1'b0;
    else if (state == BK_CHECK && !rd_occ) occ_mem[idx] <= 1'b1;
    if (state == BK_CHECK && (!rd_occ || rd_key == my_key)) begin
      key_mem[idx] <= my_key;
      val_mem[idx] <= rd_occ ? sat : item.value;
    end
    case (state)
      BK_IDLE: begin
        item <= q_data;
        rem <= '0;
        mod_bit <= 6'd31;
        probes <= '0;
      end
      BK_MOD: begin
        if (!trial[32]) rem <= trial[31:0];
        else rem <= {rem[30:0], item.hash[mod_bit[4:0]]};
        mod_bit <= mod_bit - 1'b1;
        if (mod_bit == 6'd0) idx <= (!trial[32]) ? trial[AW-1:0]
                                                 : {rem[AW-2:0], item.hash[0]};
      end
      BK_CHECK: begin
        res_slot <= idx;
        if (!rd_occ) begin
          res_status <= ST_NEW;
          res_value <= item.value;
        end else if (rd_key == my_key) begin
          res_status <= ST_ACC;
          res_value <= sat;
        end else begin
          res_status <= ST_DROP;
          res_value <= '0;
          res_slot <= '0;
        end
        probes <= probes + 1'b1;
        idx <= (idx_inc >= size) ? '0 : idx_inc[AW-1:0];
      end
      BK_CLEAR: begin
        res_status <= ST_CLEAR;
        res_slot <= '0;
        res_value <= '0;
      end
      default: ;
    endcase
  end

  assign res_valid = (state == BK_OUT);
  assign res_used = 13'(count);
endmodule
`default_nettype wire
